### design/iialu_pkg.sv
`timescale 1ns / 1ps
package iialu_pkg;

  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADOP  = 2'd1;
  localparam logic [1:0] ST_BADDIV = 2'd2;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       div_lt;
    logic       b_nonpos;
    logic       e_zero;
    logic       mul_last;
    logic       div_last;
  } dp_stat_t;

endpackage

### design/iialu_ctrl.sv
`timescale 1ns / 1ps
module iialu_ctrl
  import iialu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE:   ctl.load = in_valid;
      S_MUL:    ctl.mul_step = !stat.e_zero;
      S_DIV:    ctl.div_step = 1'b1;
      S_FINISH: ctl.out_load = !out_valid || out_ready;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.out_load) out_valid <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          case (stat.op) inside
            OP_MUL, OP_POW: state <= S_MUL;
            OP_DIV:         state <= (stat.div_lt || stat.b_nonpos) ? S_FINISH : S_DIV;
            default:        state <= S_FINISH;
          endcase
        end
        S_MUL: begin
          if (stat.e_zero) state <= S_FINISH;
        end
        S_DIV: begin
          if (stat.div_last) state <= S_FINISH;
        end
        S_FINISH: begin
          if (ctl.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/iialu_dp.sv
`timescale 1ns / 1ps
module iialu_dp
  import iialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ctl_cmd_t              ctl,
  output dp_stat_t              stat,
  input  logic [2:0]            cmd,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  output logic [DATA_WIDTH-1:0] result_value,
  output logic [DATA_WIDTH-1:0] remainder_value,
  output logic [1:0]            status_code
);

  localparam int W   = DATA_WIDTH;
  localparam int DIG = (W < 32) ? W : 32;
  localparam int ND  = (W + DIG - 1) / DIG;
  localparam int KW  = (ND > 1) ? $clog2(ND) : 1;
  localparam int CW  = $clog2(W);

  logic [2:0]    op;
  logic [W-1:0]  a_r, b_r;

  // multiply / power: acc *= sq when exponent bit set, sq *= sq
  logic [W-1:0]      acc, sq, e, p1, p2;
  logic [KW-1:0]     k;
  logic [ND*DIG-1:0] sq_pad;
  logic [DIG-1:0]    digit;
  logic [W+DIG-1:0]  m1, m2;
  logic [W-1:0]      t1, t2, p1n, p2n;
  logic              in_b_nonpos;

  // restoring divider
  logic [W-1:0]  rem, quo;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh, diff;

  logic [W-1:0]  res_c, rem_c;
  logic [1:0]    st_c;

  assign sq_pad = (ND * DIG)'(sq);
  assign digit  = sq_pad[k * DIG +: DIG];
  assign m1     = (W + DIG)'(acc) * (W + DIG)'(digit);
  assign m2     = (W + DIG)'(sq) * (W + DIG)'(digit);
  assign t1     = m1[W-1:0] << (DIG * k);
  assign t2     = m2[W-1:0] << (DIG * k);
  assign p1n    = p1 + t1;
  assign p2n    = p2 + t2;

  assign in_b_nonpos = (operand_b == '0) || operand_b[W-1];

  assign rem_sh = {rem, quo[W-1]};
  assign diff   = rem_sh - {1'b0, b_r};

  assign stat.op       = op;
  assign stat.div_lt   = $signed(a_r) < $signed(b_r);
  assign stat.b_nonpos = (b_r == '0) || b_r[W-1];
  assign stat.e_zero   = (e == '0);
  assign stat.mul_last = (k == KW'(ND - 1));
  assign stat.div_last = (cnt == CW'(W - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= cmd;
      a_r <= operand_a;
      b_r <= operand_b;
      k   <= '0;
      p1  <= '0;
      p2  <= '0;
      cnt <= '0;
      rem <= '0;
      quo <= operand_a;
      if (cmd == OP_MUL) begin
        acc <= operand_a;
        sq  <= operand_b;
        e   <= W'(1);
      end else begin
        acc <= W'(1);
        sq  <= operand_a;
        e   <= in_b_nonpos ? '0 : operand_b;
      end
    end
    if (ctl.mul_step) begin
      if (stat.mul_last) begin
        if (e[0]) acc <= p1n;
        sq <= p2n;
        e  <= e >> 1;
        k  <= '0;
        p1 <= '0;
        p2 <= '0;
      end else begin
        p1 <= p1n;
        p2 <= p2n;
        k  <= k + KW'(1);
      end
    end
    if (ctl.div_step) begin
      rem <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
      quo <= {quo[W-2:0], ~diff[W]};
      cnt <= cnt + CW'(1);
    end
    if (ctl.out_load) begin
      result_value    <= res_c;
      remainder_value <= rem_c;
      status_code     <= st_c;
    end
  end

  always_comb begin
    res_c = '0;
    rem_c = '0;
    st_c  = ST_OK;
    case (op)
      OP_ADD: res_c = a_r + b_r;
      OP_SUB: res_c = a_r - b_r;
      OP_MUL: res_c = acc;
      OP_POW: res_c = acc;
      OP_DIV: begin
        if (stat.div_lt) begin
          rem_c = a_r;
        end else if (stat.b_nonpos) begin
          st_c = ST_BADDIV;
        end else begin
          res_c = quo;
          rem_c = rem;
        end
      end
      default: st_c = ST_BADOP;
    endcase
  end

endmodule

### design/iterative_integer_alu.sv
`timescale 1ns / 1ps
// Integer ALU: add, subtract, multiply, divide with remainder, power.
// Input channel (in_valid/in_ready) carries cmd, operand_a, operand_b;
// output channel (out_valid/out_ready) returns result_value,
// remainder_value and status_code, one result item per input item.
// One item is in work at a time; in_ready is high only while idle.
// DATA_WIDTH = W, ND = ceil(W/32). Add, subtract, unknown op and the
// early divide cases need no iterative steps; multiply steps through
// the ND digits of one operand, power through them for each bit of a
// positive exponent (no steps otherwise), and divide uses a restoring
// divider, one quotient bit per cycle.
// Multiply and power share one W x min(W, 32) partial-product step per cycle;
// at W = 32 the divider and a 31-bit exponent tie for the worst case.
// A finished result waits in the output register while the receiver
// stalls; the next item is accepted meanwhile, and its result is held
// in the datapath until the output register frees up.
// Reset (rst, synchronous) returns the controller to idle and drops
// out_valid; no pending item survives it.
module iterative_integer_alu
  import iialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   cmd,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result_value,
  output logic signed [DATA_WIDTH-1:0] remainder_value,
  output logic [1:0]                   status_code
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  iialu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  iialu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .ctl             (ctl),
    .stat            (stat),
    .cmd             (cmd),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .result_value    (result_value),
    .remainder_value (remainder_value),
    .status_code     (status_code)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import iialu_pkg::*;

  localparam int DW = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS = 100;
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MINUS_ONE = '1;
  localparam logic [2:0] UNKNOWN_OPS [3] = '{3'd0, 3'd6, 3'd7};

  typedef struct packed {
    logic [DW-1:0] result;
    logic [DW-1:0] remainder;
    logic [1:0]    status;
  } alu_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           cmd = '0;
  logic signed [DW-1:0] operand_a = '0;
  logic signed [DW-1:0] operand_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] result_value;
  logic signed [DW-1:0] remainder_value;
  logic [1:0]           status_code;

  alu_result_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  iterative_integer_alu #(.DATA_WIDTH(DW)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .remainder_value(remainder_value),
    .status_code(status_code)
  );

  always #10 clk = ~clk;

  function automatic alu_result_t predict_alu(input logic [2:0] op, input logic [DW-1:0] a,
                                              input logic [DW-1:0] b);
    alu_result_t r;
    logic [DW-1:0] acc;
    logic [DW-1:0] sq;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: r.result = a + b;
      OP_SUB: r.result = a - b;
      OP_MUL: r.result = a * b;
      OP_DIV: begin
        if ($signed(a) < $signed(b)) begin
          r.remainder = a;
        end else if ($signed(b) <= 0) begin
          r.status = ST_BADDIV;
        end else begin
          r.result = a / b;
          r.remainder = a % b;
        end
      end
      OP_POW: begin
        acc = 1;
        sq = a;
        if ($signed(b) > 0) begin
          for (int i = 0; i < DW; i++) begin
            if (b[i]) acc = acc * sq;
            sq = sq * sq;
          end
        end
        r.result = acc;
      end
      default: r.status = ST_BADOP;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] random_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 32) - 16;
      2: begin
        case ($urandom_range(0, 4))
          0: v = MAX_POS;
          1: v = MIN_NEG;
          2: v = '0;
          3: v = 1;
          default: v = MINUS_ONE;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, DW - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // scoreboard: record accepted inputs, check accepted results
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) $error("result item with none expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (result_value !== exp_r.result) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $error("result_value: expected %0d, got %0d", $signed(exp_r.result), result_value);
          end
          if (remainder_value !== exp_r.remainder) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $error("remainder_value: expected %0d, got %0d", $signed(exp_r.remainder),
                     remainder_value);
          end
          if (status_code !== exp_r.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $error("status_code: expected %0d, got %0d", exp_r.status, status_code);
          end
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_alu(cmd, operand_a, operand_b));
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && pending_results.size() == 0)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("iterative_integer_alu: mismatch");
    $finish;
  end

  // valid stays high from one item to the next unless the sender idles
  task automatic send_item(input logic [2:0] op, input logic [DW-1:0] a,
                           input logic [DW-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_add_sub();
    send_item(OP_ADD, MAX_POS, 1);
    send_item(OP_ADD, MIN_NEG, MINUS_ONE);
    send_item(OP_ADD, '0, '0);
    send_item(OP_SUB, MIN_NEG, 1);
    send_item(OP_SUB, '0, MIN_NEG);
  endtask

  task automatic test_multiply();
    send_item(OP_MUL, MAX_POS, MAX_POS);
    send_item(OP_MUL, MIN_NEG, MINUS_ONE);
    send_item(OP_MUL, -3, 7);
    send_item(OP_MUL, '0, MIN_NEG);
    send_item(OP_MUL, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_divide();
    send_item(OP_DIV, 3, 10);           // dividend below divisor
    send_item(OP_DIV, -5, 3);           // negative dividend below divisor
    send_item(OP_DIV, 100, '0);         // zero divisor
    send_item(OP_DIV, 5, -3);           // negative divisor
    send_item(OP_DIV, MIN_NEG, MIN_NEG);
    send_item(OP_DIV, MAX_POS, 1);
    send_item(OP_DIV, MAX_POS, MAX_POS);
  endtask

  task automatic test_power();
    send_item(OP_POW, 2, 31);
    send_item(OP_POW, 3, '0);           // zero exponent
    send_item(OP_POW, 5, MINUS_ONE);    // negative exponent
    send_item(OP_POW, -2, 3);
    send_item(OP_POW, 7, MAX_POS);
  endtask

  task automatic test_unknown_op();
    foreach (UNKNOWN_OPS[i]) send_item(UNKNOWN_OPS[i], MINUS_ONE, MAX_POS);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    logic [2:0] op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < 6) op = UNKNOWN_OPS[$urandom_range(0, 2)];
      else op = 3'($urandom_range(OP_ADD, OP_POW));
      a = random_operand();
      b = random_operand();
      if (op == OP_DIV && $urandom_range(0, 99) < 60) begin
        b = ($urandom >> $urandom_range(1, DW - 1)) | 1;
        a = b + ($urandom % (MAX_POS - b + 1));
      end else if (op == OP_POW && $urandom_range(0, 99) < 70) begin
        b = $urandom_range(0, 40);
      end
      send_item(op, a, b);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 52;
    test_add_sub();
    test_multiply();
    test_divide();
    test_power();
    test_unknown_op();
    test_random_traffic(32, 52, 660);
    test_random_traffic(52, 32, 660);
    test_random_traffic(0, 0, 660);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("iterative_integer_alu: match");
    end else begin
      $display("iterative_integer_alu: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/iialu_pkg.sv
design/iialu_ctrl.sv
design/iialu_dp.sv
design/iterative_integer_alu.sv
sim/testbench.sv
